// ----- hdl/wce_pkg.sv -----
// Shared types, codes and constants of the wall centering error block.
package wce_pkg;

    localparam int READING_W = 12;
    localparam int SPEED_W   = 11;
    localparam int CORR_W    = 8;
    localparam int COUNT_W   = 8;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam int SETTLE_LIMIT_DEFAULT = 200;

    localparam logic [READING_W-1:0] LEFT_REF_RESET  = 12'd1035;
    localparam logic [READING_W-1:0] RIGHT_REF_RESET = 12'd1063;

    localparam logic [CMD_W-1:0] CMD_SAMPLE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MOVE_END   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_REF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_REF = 2'd1;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [READING_W-1:0]     left_reading;
        logic [READING_W-1:0]     right_reading;
        logic signed [SPEED_W-1:0] left_wheel_speed;
        logic signed [SPEED_W-1:0] right_wheel_speed;
    } wce_item_t;

    typedef struct packed {
        logic [READING_W-1:0] left_ref;
        logic [READING_W-1:0] right_ref;
    } wce_refs_t;

endpackage

// ----- hdl/wce_in_reg.sv -----
// Input register stage holding one input transfer for the step logic.
module wce_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wce_pkg::wce_item_t  in_item,
    input  logic                advance,
    output logic                item_valid,
    output wce_pkg::wce_item_t  item
);

    logic               valid_reg;
    logic               valid_next;
    wce_pkg::wce_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- hdl/wce_core.sv -----
// Steering error step logic with settle counter and held corrections.
module wce_core
#(
    parameter int SETTLE_LIMIT = wce_pkg::SETTLE_LIMIT_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  wce_pkg::wce_item_t                  item,
    input  wce_pkg::wce_refs_t                  refs,
    output logic signed [wce_pkg::CORR_W-1:0]   left_corr,
    output logic signed [wce_pkg::CORR_W-1:0]   right_corr
);

    localparam logic [wce_pkg::COUNT_W-1:0] LIMIT_C = wce_pkg::COUNT_W'(SETTLE_LIMIT);

    logic [wce_pkg::COUNT_W-1:0]       settle_count_reg;
    logic [wce_pkg::COUNT_W-1:0]       settle_count_next;
    logic signed [wce_pkg::CORR_W-1:0] held_left_reg;
    logic signed [wce_pkg::CORR_W-1:0] held_left_next;
    logic signed [wce_pkg::CORR_W-1:0] held_right_reg;
    logic signed [wce_pkg::CORR_W-1:0] held_right_next;

    logic               left_seen;
    logic               right_seen;
    logic signed [14:0] diff_both;
    logic signed [14:0] diff_left;
    logic signed [14:0] diff_right;
    logic signed [14:0] numer;
    logic [12:0]        numer_mag;
    logic [25:0]        err_prod;
    logic [8:0]         err_mag;
    logic signed [9:0]  err;
    logic [10:0]        speed_mag;
    logic [20:0]        speed_prod;
    logic [6:0]         lim_mag;
    logic signed [9:0]  lim;
    logic signed [9:0]  lim_neg;
    logic signed [9:0]  clamp_hi;
    logic signed [9:0]  clamp_out;
    logic signed [9:0]  corr;
    logic               single_drop;

    assign left_seen  = ({1'b0, item.left_reading} + 13'd50) > {1'b0, refs.left_ref};
    assign right_seen = ({1'b0, item.right_reading} + 13'd50) > {1'b0, refs.right_ref};

    assign diff_both  = $signed({3'b000, item.left_reading}) - $signed({3'b000, item.right_reading})
                      - $signed({3'b000, refs.left_ref}) + $signed({3'b000, refs.right_ref});
    assign diff_left  = $signed({3'b000, item.left_reading}) - $signed({3'b000, refs.left_ref});
    assign diff_right = $signed({3'b000, item.right_reading}) - $signed({3'b000, refs.right_ref});

    always_comb
    begin
        if (left_seen && right_seen)
        begin
            numer = diff_both;
        end
        else if (left_seen)
        begin
            numer = diff_left;
        end
        else
        begin
            numer = diff_right;
        end
    end

    // divide by 25 through reciprocal 5243 / 2^17, exact below 2^13
    assign numer_mag = numer[14] ? 13'(-numer) : numer[12:0];
    assign err_prod  = 26'(numer_mag) * 26'd5243;
    assign err_mag   = err_prod[25:17];
    assign err       = numer[14] ? -$signed({1'b0, err_mag}) : $signed({1'b0, err_mag});

    // divide by 15 through reciprocal 1093 / 2^14, exact below 1489
    assign speed_mag  = item.left_wheel_speed[10] ? 11'(-item.left_wheel_speed)
                                                  : item.left_wheel_speed;
    assign speed_prod = 21'(speed_mag) * 21'd1093;
    assign lim_mag    = speed_prod[20:14];
    assign lim        = item.left_wheel_speed[10] ? -$signed({3'b000, lim_mag})
                                                  : $signed({3'b000, lim_mag});
    assign lim_neg    = -lim;

    assign clamp_hi    = (err > lim) ? lim : err;
    assign clamp_out   = (clamp_hi < lim_neg) ? lim_neg : clamp_hi;
    assign single_drop = !(left_seen && right_seen) && (err < -10'sd15);
    assign corr        = single_drop ? 10'sd0 : clamp_out;

    always_comb
    begin
        settle_count_next = settle_count_reg;
        held_left_next    = held_left_reg;
        held_right_next   = held_right_reg;
        unique case (item.cmd)
            wce_pkg::CMD_SAMPLE:
            begin
                if (item.left_wheel_speed == item.right_wheel_speed)
                begin
                    if (!left_seen && !right_seen)
                    begin
                        settle_count_next = '0;
                        held_left_next    = '0;
                        held_right_next   = '0;
                    end
                    else if (settle_count_reg <= LIMIT_C)
                    begin
                        settle_count_next = settle_count_reg + 1'b1;
                    end
                    else if (left_seen)
                    begin
                        held_left_next  = corr[7:0];
                        held_right_next = 8'(-corr);
                    end
                    else
                    begin
                        held_left_next  = 8'(-corr);
                        held_right_next = corr[7:0];
                    end
                end
            end
            wce_pkg::CMD_MOVE_START:
            begin
                settle_count_next = '0;
            end
            wce_pkg::CMD_MOVE_END:
            begin
                held_left_next  = '0;
                held_right_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_count_reg <= '0;
            held_left_reg    <= '0;
            held_right_reg   <= '0;
        end
        else if (fire)
        begin
            settle_count_reg <= settle_count_next;
            held_left_reg    <= held_left_next;
            held_right_reg   <= held_right_next;
        end
    end

    assign left_corr  = held_left_reg;
    assign right_corr = held_right_reg;

endmodule

// ----- hdl/wall_centering_error_top.sv -----
// Top level of the wall centering error block: handshakes, references, result stage.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready    | cmd, readings, wheel speeds
//  out     | output    | out_valid / out_ready  | left_correction, right_correction
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One transfer per cycle in steady state; a result is offered once its input transfer
// has passed the input register and the step logic into the held correction registers.
// The held corrections are the result register; they update only when the result slot
// is free, so a stalled output holds and the input side stalls one item behind it.
// Reset clears the settle counter and corrections and loads the default references.
// cfg_ready is always high.
module wall_centering_error_top
#(
    parameter int SETTLE_LIMIT = wce_pkg::SETTLE_LIMIT_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [wce_pkg::CMD_W-1:0]              cmd,
    input  logic [wce_pkg::READING_W-1:0]          left_reading,
    input  logic [wce_pkg::READING_W-1:0]          right_reading,
    input  logic signed [wce_pkg::SPEED_W-1:0]     left_wheel_speed,
    input  logic signed [wce_pkg::SPEED_W-1:0]     right_wheel_speed,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [wce_pkg::CORR_W-1:0]      left_correction,
    output logic signed [wce_pkg::CORR_W-1:0]      right_correction,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [wce_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [wce_pkg::READING_W-1:0]          cfg_data
);

    wce_pkg::wce_item_t in_item;
    wce_pkg::wce_item_t item;
    wce_pkg::wce_refs_t refs;
    logic               item_valid;
    logic               advance;
    logic               fire;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [wce_pkg::READING_W-1:0] left_ref_reg;
    logic [wce_pkg::READING_W-1:0] right_ref_reg;

    assign in_item.cmd               = cmd;
    assign in_item.left_reading      = left_reading;
    assign in_item.right_reading     = right_reading;
    assign in_item.left_wheel_speed  = left_wheel_speed;
    assign in_item.right_wheel_speed = right_wheel_speed;

    assign advance = !out_valid_reg || out_ready;
    assign fire    = advance && item_valid;

    wce_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    assign refs.left_ref  = left_ref_reg;
    assign refs.right_ref = right_ref_reg;

    wce_core #(
        .SETTLE_LIMIT (SETTLE_LIMIT)
    ) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item),
        .refs       (refs),
        .left_corr  (left_correction),
        .right_corr (right_correction)
    );

    assign out_valid_next = advance ? item_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_ref_reg  <= wce_pkg::LEFT_REF_RESET;
            right_ref_reg <= wce_pkg::RIGHT_REF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wce_pkg::CFG_LEFT_REF:  left_ref_reg  <= cfg_data;
                wce_pkg::CFG_RIGHT_REF: right_ref_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule
